/* hw/rtl/morse_letter_keyer_macros.svh */
`ifndef MORSE_LETTER_KEYER_MACROS_SVH
`define MORSE_LETTER_KEYER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MLK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define MLK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/mlk_pkg.sv */
package mlk_pkg;

    localparam int DUR_W   = 12;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 3;
    localparam int LEN_W   = 3;
    localparam int PAT_W   = 4;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [IDX_W-1:0] CFG_DOT_TIME     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_DASH_TIME    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ELEMENT_GAP  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_LETTER_GAP   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_WORD_GAP     = 3'd4;

    localparam logic [DUR_W-1:0] RST_DOT_TIME     = 12'd100;
    localparam logic [DUR_W-1:0] RST_DASH_TIME    = 12'd300;
    localparam logic [DUR_W-1:0] RST_ELEMENT_GAP  = 12'd50;
    localparam logic [DUR_W-1:0] RST_LETTER_GAP   = 12'd400;
    localparam logic [DUR_W-1:0] RST_WORD_GAP     = 12'd600;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [1:0] {
        SYM_DOT        = 2'd0,
        SYM_DASH       = 2'd1,
        SYM_LETTER_GAP = 2'd2,
        SYM_WORD_GAP   = 2'd3
    } t_symbol;

    // one classified character; pattern is left aligned, 1 = dash
    typedef struct packed {
        logic             word;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
    } t_job;

    typedef struct packed {
        logic              full;
        logic              empty;
    } t_q_stat;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
        logic [DUR_W-1:0] data;
    } t_cfg_wr;

    function automatic t_job letter_code(input logic [4:0] idx);
        t_job j;
        j.word = 1'b0;
        case (idx)
            5'd0:    begin j.len = 3'd2; j.pat = 4'b0100; end
            5'd1:    begin j.len = 3'd4; j.pat = 4'b1000; end
            5'd2:    begin j.len = 3'd4; j.pat = 4'b1010; end
            5'd3:    begin j.len = 3'd3; j.pat = 4'b1000; end
            5'd4:    begin j.len = 3'd1; j.pat = 4'b0000; end
            5'd5:    begin j.len = 3'd4; j.pat = 4'b0010; end
            5'd6:    begin j.len = 3'd3; j.pat = 4'b1100; end
            5'd7:    begin j.len = 3'd4; j.pat = 4'b0000; end
            5'd8:    begin j.len = 3'd2; j.pat = 4'b0000; end
            5'd9:    begin j.len = 3'd4; j.pat = 4'b0111; end
            5'd10:   begin j.len = 3'd3; j.pat = 4'b1010; end
            5'd11:   begin j.len = 3'd4; j.pat = 4'b0100; end
            5'd12:   begin j.len = 3'd2; j.pat = 4'b1100; end
            5'd13:   begin j.len = 3'd2; j.pat = 4'b1000; end
            5'd14:   begin j.len = 3'd3; j.pat = 4'b1110; end
            5'd15:   begin j.len = 3'd4; j.pat = 4'b0110; end
            5'd16:   begin j.len = 3'd4; j.pat = 4'b1101; end
            5'd17:   begin j.len = 3'd3; j.pat = 4'b0100; end
            5'd18:   begin j.len = 3'd3; j.pat = 4'b0000; end
            5'd19:   begin j.len = 3'd1; j.pat = 4'b1000; end
            5'd20:   begin j.len = 3'd3; j.pat = 4'b0010; end
            5'd21:   begin j.len = 3'd4; j.pat = 4'b0001; end
            5'd22:   begin j.len = 3'd3; j.pat = 4'b0110; end
            5'd23:   begin j.len = 3'd4; j.pat = 4'b1001; end
            5'd24:   begin j.len = 3'd4; j.pat = 4'b1011; end
            5'd25:   begin j.len = 3'd4; j.pat = 4'b1100; end
            default: begin j.len = 3'd0; j.pat = 4'b0000; end
        endcase
        return j;
    endfunction

endpackage

/* hw/rtl/morse_letter_keyer.sv */
// channel   direction  handshake                  payload
// char      in         i_start, o_busy            i_char_code
// config    in         i_cfg_valid, o_cfg_ready   i_cfg_index, i_cfg_data
// result    out        o_strobe (per word)        o_symbol, o_mark_ms, o_space_ms, o_last
//
// a letter gives len+1 words on consecutive cycles (2 to 5), a space gives 1,
// other bytes give none; the back end emits one word per cycle while jobs are queued
// from an empty queue, a first word passes front reg, queue, back-end state and output reg
// a four-entry queue plus the front register absorb bursts; o_busy rises when both are full
// reset is synchronous, active low, and restores the default timings
// the receiver cannot stall; o_cfg_ready is always high
`include "morse_letter_keyer_macros.svh"

module morse_letter_keyer
    import mlk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [DUR_W-1:0]  i_cfg_data,
    output logic              o_strobe,
    output logic [1:0]        o_symbol,
    output logic [DUR_W-1:0]  o_mark_ms,
    output logic [DUR_W-1:0]  o_space_ms,
    output logic              o_last
);

    t_q_stat q_stat;
    t_job    front_job;
    t_job    q_job;
    logic    push;
    logic    pop;
    t_cfg_wr cfg_wr;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid && o_cfg_ready;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    mlk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_char_code (i_char_code),
        .i_q_stat    (q_stat),
        .o_busy      (o_busy),
        .o_push      (push),
        .o_job       (front_job)
    );

    mlk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    mlk_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_wr),
        .i_job      (q_job),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_strobe   (o_strobe),
        .o_symbol   (o_symbol),
        .o_mark_ms  (o_mark_ms),
        .o_space_ms (o_space_ms),
        .o_last     (o_last)
    );

    `MLK_ASSERT_NOW(a_gap_is_last, i_clk, i_rst_n,
        o_strobe && (o_symbol == SYM_LETTER_GAP || o_symbol == SYM_WORD_GAP),
        o_last && (o_mark_ms == '0))
    `MLK_ASSERT_NOW(a_last_is_gap, i_clk, i_rst_n,
        o_strobe && o_last,
        o_symbol == SYM_LETTER_GAP || o_symbol == SYM_WORD_GAP)
    `MLK_ASSERT_NOW(a_busy_only_when_full, i_clk, i_rst_n,
        o_busy, q_stat.full)
    `MLK_ASSERT_NEXT(a_pop_gives_word, i_clk, i_rst_n,
        pop, ##1 o_strobe)

endmodule

/* hw/rtl/mlk_front.sv */
module mlk_front
    import mlk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CHAR_W-1:0] i_char_code,
    input  t_q_stat           i_q_stat,
    output logic              o_busy,
    output logic              o_push,
    output t_job              o_job
);

    logic              r_valid;
    t_job              r_job;
    logic              n_valid;
    t_job              n_job;
    logic              accept;
    logic              is_upper;
    logic              is_lower;
    logic              is_space;
    logic [CHAR_W-1:0] offset;

    assign o_busy = r_valid && i_q_stat.full;
    assign accept = i_start && !o_busy;
    assign o_push = r_valid && !i_q_stat.full;
    assign o_job  = r_job;

    always_comb begin
        is_upper = (i_char_code >= CHAR_UPPER_A) && (i_char_code <= CHAR_UPPER_Z);
        is_lower = (i_char_code >= CHAR_LOWER_A) && (i_char_code <= CHAR_LOWER_Z);
        is_space = (i_char_code == CHAR_SPACE);
        offset   = is_upper ? (i_char_code - CHAR_UPPER_A) : (i_char_code - CHAR_LOWER_A);
        n_job    = letter_code(offset[4:0]);
        if (is_space) begin
            n_job.word = 1'b1;
            n_job.len  = '0;
            n_job.pat  = '0;
        end
        n_valid = r_valid && i_q_stat.full;
        if (accept) begin
            n_valid = is_upper || is_lower || is_space;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

/* hw/rtl/mlk_queue.sv */
module mlk_queue
    import mlk_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* hw/rtl/mlk_back.sv */
module mlk_back
    import mlk_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg_wr          i_cfg,
    input  t_job             i_job,
    input  t_q_stat          i_q_stat,
    output logic             o_pop,
    output logic             o_strobe,
    output logic [1:0]       o_symbol,
    output logic [DUR_W-1:0] o_mark_ms,
    output logic [DUR_W-1:0] o_space_ms,
    output logic             o_last
);

    logic [DUR_W-1:0] r_dot;
    logic [DUR_W-1:0] r_dash;
    logic [DUR_W-1:0] r_elem_gap;
    logic [DUR_W-1:0] r_letter_gap;
    logic [DUR_W-1:0] r_word_gap;

    logic             r_act;
    logic             r_word;
    logic [LEN_W-1:0] r_left;
    logic [PAT_W-1:0] r_pat;

    logic             r_strobe;
    t_symbol          r_symbol;
    logic [DUR_W-1:0] r_mark;
    logic [DUR_W-1:0] r_space;
    logic             r_last;

    logic             finish;
    t_symbol          n_symbol;
    logic [DUR_W-1:0] n_mark;
    logic [DUR_W-1:0] n_space;

    assign finish = r_act && (r_word || (r_left == '0));
    assign o_pop  = (!r_act || finish) && !i_q_stat.empty;

    always_comb begin
        if (r_word) begin
            n_symbol = SYM_WORD_GAP;
            n_mark   = '0;
            n_space  = r_word_gap;
        end else if (r_left == '0) begin
            n_symbol = SYM_LETTER_GAP;
            n_mark   = '0;
            n_space  = r_letter_gap;
        end else if (r_pat[PAT_W-1]) begin
            n_symbol = SYM_DASH;
            n_mark   = r_dash;
            n_space  = r_elem_gap;
        end else begin
            n_symbol = SYM_DOT;
            n_mark   = r_dot;
            n_space  = r_elem_gap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot        <= RST_DOT_TIME;
            r_dash       <= RST_DASH_TIME;
            r_elem_gap   <= RST_ELEMENT_GAP;
            r_letter_gap <= RST_LETTER_GAP;
            r_word_gap   <= RST_WORD_GAP;
            r_act        <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_DOT_TIME:    r_dot        <= i_cfg.data;
                    CFG_DASH_TIME:   r_dash       <= i_cfg.data;
                    CFG_ELEMENT_GAP: r_elem_gap   <= i_cfg.data;
                    CFG_LETTER_GAP:  r_letter_gap <= i_cfg.data;
                    CFG_WORD_GAP:    r_word_gap   <= i_cfg.data;
                    default:         ;
                endcase
            end
            r_strobe <= r_act;
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (finish) begin
                r_act <= 1'b0;
            end
        end
        if (o_pop) begin
            r_word <= i_job.word;
            r_left <= i_job.len;
            r_pat  <= i_job.pat;
        end else if (r_act && !finish) begin
            r_left <= r_left - 1'b1;
            r_pat  <= {r_pat[PAT_W-2:0], 1'b0};
        end
        r_symbol <= n_symbol;
        r_mark   <= n_mark;
        r_space  <= n_space;
        r_last   <= finish;
    end

    assign o_strobe   = r_strobe;
    assign o_symbol   = r_symbol;
    assign o_mark_ms  = r_mark;
    assign o_space_ms = r_space;
    assign o_last     = r_last;

endmodule
